>>> design/ttkm_pkg.sv
// Shared types and constants of the tournament-tree k-way merge.
// Used by ttkm_ctrl, ttkm_datapath and tournament_tree_kway_merge.
package ttkm_pkg;

  // Fixed field widths of the stream words
  localparam int STAMP_W   = 63;
  localparam int PAY_W     = 64;
  localparam int LANE_FW   = 4;
  localparam int TDATA_I_W = 136;
  localparam int TDATA_O_W = 136;

  // Bit positions inside the input tdata word
  localparam int LANE_LSB  = 0;
  localparam int STAMP_LSB = LANE_LSB + LANE_FW;
  localparam int PAY_LSB   = STAMP_LSB + STAMP_W;
  localparam int ENDED_BIT = PAY_LSB + PAY_W;

  typedef enum logic {
    KIND_REFILL = 1'b0,
    KIND_POP    = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_EVENT = 2'd0,
    ST_END   = 2'd1,
    ST_WAIT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_POP
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;      // write the lane, seed the replay, read level-0 sibling
    logic    merge;     // compare one tree level, write the node, read next sibling
    logic    rd_pay;    // read the root winner's payload
    logic    out_load;  // capture the result word
    status_e st;        // status of the captured result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic root_empty;   // overall winner holds no event
  } sts_t;

endpackage

>>> design/ttkm_ctrl.sv
// Controller of the tournament-tree merge: handshakes, replay sequencing,
// refill wait tracking. Depends on ttkm_pkg.
module ttkm_ctrl import ttkm_pkg::*; #(
  parameter int LANES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  kind_e                              in_kind_i,
  input  logic [LANE_FW-1:0]                 in_lane_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  sts_t                               sts_i,
  input  logic [$clog2(LANES)-1:0]           root_lane_i,
  output cmd_t                               cmd_o,
  output logic [$clog2($clog2(LANES)+1)-1:0] lvl_o,
  output logic [$clog2(LANES)-1:0]           pend_lane_o
);

  localparam int LEVELS = $clog2(LANES);
  localparam int LW     = LEVELS;
  localparam int LVW    = $clog2(LEVELS + 1);

  state_e            state_q, state_d;
  logic [LVW-1:0]    lvl_q, lvl_d;
  logic              pend_q, pend_d;
  logic [LW-1:0]     pend_lane_q, pend_lane_d;
  status_e           st_q, st_d;
  logic              out_vld_q, out_vld_d;
  logic              lane_ok;
  logic [LW-1:0]     lane_in;

  assign lane_ok = (int'(in_lane_i) < LANES);
  assign lane_in = LW'(in_lane_i);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      pend_q      <= 1'b0;
      pend_lane_q <= '0;
      st_q        <= ST_EVENT;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      pend_q      <= pend_d;
      pend_lane_q <= pend_lane_d;
      st_q        <= st_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Sequence refills and pops
  always_comb begin
    state_d        = state_q;
    lvl_d          = lvl_q;
    pend_d         = pend_q;
    pend_lane_d    = pend_lane_q;
    st_d           = st_q;
    out_vld_d      = out_vld_q;
    cmd_o.load     = 1'b0;
    cmd_o.merge    = 1'b0;
    cmd_o.rd_pay   = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.st       = st_q;

    // Drop the result word once taken
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_REFILL) begin
            // A lane beyond the tree is ignored
            if (lane_ok) begin
              cmd_o.load = 1'b1;
              lvl_d      = LVW'(1);
              state_d    = S_MERGE;
              if (pend_q && (lane_in == pend_lane_q)) begin
                pend_d = 1'b0;
              end
            end
          end else begin
            cmd_o.rd_pay = 1'b1;
            state_d      = S_POP;
            if (pend_q) begin
              st_d = ST_WAIT;
            end else if (sts_i.root_empty) begin
              st_d = ST_END;
            end else begin
              st_d        = ST_EVENT;
              pend_d      = 1'b1;
              pend_lane_d = root_lane_i;
            end
          end
        end
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        lvl_d       = lvl_q + LVW'(1);
        if (lvl_q == LVW'(LEVELS)) begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        // Wait for the output register to free up
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_vld_d      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;
  assign lvl_o       = lvl_q;
  assign pend_lane_o = pend_lane_q;

endmodule

>>> design/ttkm_datapath.sv
// Datapath of the tournament-tree merge: lane stores, node winner memory,
// one node compare unit, root register and result word. Depends on ttkm_pkg.
module ttkm_datapath import ttkm_pkg::*; #(
  parameter int LANES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cmd_t                               cmd_i,
  input  logic [$clog2($clog2(LANES)+1)-1:0] lvl_i,
  input  logic [$clog2(LANES)-1:0]           in_lane_i,
  input  logic [STAMP_W-1:0]                 in_stamp_i,
  input  logic [PAY_W-1:0]                   in_pay_i,
  input  logic                               in_ended_i,
  input  logic [$clog2(LANES)-1:0]           pend_lane_i,
  output sts_t                               sts_o,
  output logic [$clog2(LANES)-1:0]           root_lane_o,
  output status_e                            out_st_o,
  output logic [LANE_FW-1:0]                 out_lane_o,
  output logic [STAMP_W-1:0]                 out_stamp_o,
  output logic [PAY_W-1:0]                   out_pay_o
);

  localparam int LEVELS = $clog2(LANES);
  localparam int LW     = LEVELS;
  localparam int LVW    = $clog2(LEVELS + 1);
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = LEAVES - 1;

  typedef struct packed {
    logic [LW-1:0]      lane;
    logic               empty;
    logic [STAMP_W-1:0] stamp;
  } node_t;

  // Lane stores and node memory
  logic [STAMP_W-1:0] stamp_mem [LEAVES];
  logic [PAY_W-1:0]   pay_mem   [LEAVES];
  node_t              node_mem  [NODES];
  logic [LEAVES-1:0]  lane_empty_q;
  logic [NODES-1:0]   node_vld_q;
  node_t              root_q;

  // Replay registers
  logic [LW-1:0]      path_q;
  logic [LW-1:0]      run_lane_q;
  logic               run_empty_q;
  logic [STAMP_W-1:0] run_stamp_q;
  logic               sib_leaf_q;
  logic               sib_vld_q;
  logic [LW-1:0]      sib_lane_q;
  logic               sib_empty_q;
  logic [STAMP_W-1:0] leaf_rd_q;
  node_t              node_rd_q;
  logic [PAY_W-1:0]   pay_rd_q;

  // Result word
  status_e            out_st_q;
  logic [LANE_FW-1:0] out_lane_q;
  logic [STAMP_W-1:0] out_stamp_q;
  logic [PAY_W-1:0]   out_pay_q;

  logic [LW-1:0]      path_pos;
  logic [LW-1:0]      sib_pos;
  logic [LW:0]        lvl_base;
  logic [LW:0]        par_full;
  logic [LW:0]        sib_full;
  logic [LW-1:0]      par_h;
  logic [LW-1:0]      sib_h;
  logic               top_lvl;
  logic               use_reg;
  logic [LW-1:0]      sib_lane;
  logic               sib_empty;
  logic [STAMP_W-1:0] sib_stamp;
  logic               sib_wins;
  node_t              win;

  // Node addressing at the current level: heap base plus position
  assign path_pos = path_q >> lvl_i;
  assign sib_pos  = path_pos ^ LW'(1);
  assign lvl_base = (LW + 1)'(LEAVES) >> lvl_i;
  assign par_full = lvl_base - (LW + 1)'(1) + {1'b0, path_pos};
  assign sib_full = lvl_base - (LW + 1)'(1) + {1'b0, sib_pos};
  assign par_h    = par_full[LW-1:0];
  assign sib_h    = sib_full[LW-1:0];
  assign top_lvl  = (lvl_i == LVW'(LEVELS));

  // Select the sibling subtree's winner; unwritten nodes hold their leftmost leaf
  assign use_reg   = sib_leaf_q || !sib_vld_q;
  assign sib_lane  = use_reg ? sib_lane_q : node_rd_q.lane;
  assign sib_empty = use_reg ? sib_empty_q : node_rd_q.empty;
  assign sib_stamp = sib_leaf_q ? leaf_rd_q : node_rd_q.stamp;

  // Compare: an event beats an empty lane, then earlier stamp, then lower lane
  always_comb begin
    if (run_empty_q) begin
      sib_wins = !sib_empty || (sib_lane < run_lane_q);
    end else begin
      sib_wins = !sib_empty &&
                 ((sib_stamp < run_stamp_q) ||
                  ((sib_stamp == run_stamp_q) && (sib_lane < run_lane_q)));
    end
    if (sib_wins) begin
      win.lane  = sib_lane;
      win.empty = sib_empty;
      win.stamp = sib_stamp;
    end else begin
      win.lane  = run_lane_q;
      win.empty = run_empty_q;
      win.stamp = run_stamp_q;
    end
  end

  // Hold lane empty flags, node valid flags and the root winner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_empty_q <= '1;
      node_vld_q   <= '0;
      root_q.lane  <= '0;
      root_q.empty <= 1'b1;
      root_q.stamp <= '0;
    end else begin
      if (cmd_i.load) begin
        lane_empty_q[in_lane_i] <= in_ended_i;
      end
      if (cmd_i.merge) begin
        if (top_lvl) begin
          root_q <= win;
        end else begin
          node_vld_q[par_h] <= 1'b1;
        end
      end
    end
  end

  // Write the memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !in_ended_i) begin
      stamp_mem[in_lane_i] <= in_stamp_i;
      pay_mem[in_lane_i]   <= in_pay_i;
    end
    if (cmd_i.merge && !top_lvl) begin
      node_mem[par_h] <= win;
    end
  end

  // Read the memories and advance the replay
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      path_q      <= in_lane_i;
      run_lane_q  <= in_lane_i;
      run_empty_q <= in_ended_i;
      run_stamp_q <= in_stamp_i;
      sib_leaf_q  <= 1'b1;
      sib_lane_q  <= in_lane_i ^ LW'(1);
      sib_empty_q <= lane_empty_q[in_lane_i ^ LW'(1)];
      leaf_rd_q   <= stamp_mem[in_lane_i ^ LW'(1)];
    end
    if (cmd_i.merge) begin
      run_lane_q  <= win.lane;
      run_empty_q <= win.empty;
      run_stamp_q <= win.stamp;
      if (!top_lvl) begin
        sib_leaf_q  <= 1'b0;
        sib_vld_q   <= node_vld_q[sib_h];
        sib_lane_q  <= sib_pos << lvl_i;
        sib_empty_q <= 1'b1;
        node_rd_q   <= node_mem[sib_h];
      end
    end
    if (cmd_i.rd_pay) begin
      pay_rd_q <= pay_mem[root_q.lane];
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_st_q <= cmd_i.st;
      case (cmd_i.st)
        ST_EVENT: begin
          out_lane_q  <= LANE_FW'(pend_lane_i);
          out_stamp_q <= root_q.stamp;
          out_pay_q   <= pay_rd_q;
        end
        ST_WAIT: begin
          out_lane_q  <= LANE_FW'(pend_lane_i);
          out_stamp_q <= '0;
          out_pay_q   <= '0;
        end
        default: begin
          out_lane_q  <= '0;
          out_stamp_q <= '0;
          out_pay_q   <= '0;
        end
      endcase
    end
  end

  assign sts_o.root_empty = root_q.empty;
  assign root_lane_o      = root_q.lane;
  assign out_st_o         = out_st_q;
  assign out_lane_o       = out_lane_q;
  assign out_stamp_o      = out_stamp_q;
  assign out_pay_o        = out_pay_q;

endmodule

>>> design/tournament_tree_kway_merge.sv
// Top level of the tournament-tree k-way merge: stream ports, controller
// and datapath. Depends on ttkm_pkg, ttkm_ctrl and ttkm_datapath.
//
// Merges up to LANES timestamped event sources with a winner tree. Each lane
// buffers one event. A refill word (tuser = 0) writes a lane's stamp and
// payload, or marks it exhausted, and replays its leaf-to-root path; it gives
// no result: the lane write comes first, then one compare per tree level
// through the single node compare unit, with the sibling winners read from
// the node memory one level ahead. A pop word (tuser = 1) gives one result:
// the earliest event and its lane (status 0), end when every lane is
// exhausted (status 1), or waiting with the awaited lane while the last
// given lane is not yet refilled (status 2). A pop reads the payload memory
// in the accepting cycle and then captures the result word, waiting while
// the previous result waits to be taken. Equal stamps go to the lower lane.
// No clearing pass is needed after reset. Refills of lanes at or beyond
// LANES are dropped.
module tournament_tree_kway_merge import ttkm_pkg::*; #(
  parameter int LANES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // lane[3:0], stamp[66:4], payload[130:67], ended[131], zero fill [135:132]
  input  logic [TDATA_I_W-1:0] s_axis_tdata,
  // kind[0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // from_lane[3:0], out_stamp[66:4], out_payload[130:67], zero fill [135:131]
  output logic [TDATA_O_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]           m_axis_tuser
);

  localparam int LW  = $clog2(LANES);
  localparam int LVW = $clog2(LW + 1);

  cmd_t               cmd;
  sts_t               sts;
  logic [LVW-1:0]     lvl;
  logic [LW-1:0]      root_lane;
  logic [LW-1:0]      pend_lane;
  logic [LANE_FW-1:0] in_lane;
  status_e            out_st;
  logic [LANE_FW-1:0] out_lane;
  logic [STAMP_W-1:0] out_stamp;
  logic [PAY_W-1:0]   out_pay;

  assign in_lane = s_axis_tdata[STAMP_LSB-1:LANE_LSB];

  ttkm_ctrl #(
    .LANES (LANES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (kind_e'(s_axis_tuser)),
    .in_lane_i   (in_lane),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .root_lane_i (root_lane),
    .cmd_o       (cmd),
    .lvl_o       (lvl),
    .pend_lane_o (pend_lane)
  );

  ttkm_datapath #(
    .LANES (LANES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .lvl_i       (lvl),
    .in_lane_i   (LW'(in_lane)),
    .in_stamp_i  (s_axis_tdata[PAY_LSB-1:STAMP_LSB]),
    .in_pay_i    (s_axis_tdata[ENDED_BIT-1:PAY_LSB]),
    .in_ended_i  (s_axis_tdata[ENDED_BIT]),
    .pend_lane_i (pend_lane),
    .sts_o       (sts),
    .root_lane_o (root_lane),
    .out_st_o    (out_st),
    .out_lane_o  (out_lane),
    .out_stamp_o (out_stamp),
    .out_pay_o   (out_pay)
  );

  // Pack the result word
  assign m_axis_tdata = {(TDATA_O_W - PAY_W - STAMP_W - LANE_FW)'(0),
                         out_pay, out_stamp, out_lane};
  assign m_axis_tuser = out_st;

  // A refill never raises a result
  a_refill_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_REFILL) && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("refill produced a result word");

  // A pop with a free output gives its result once the pop state captures the result word
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_POP) && !m_axis_tvalid
    |-> ##2 m_axis_tvalid)
    else $error("pop result did not appear");

  // A given event comes from an existing lane
  a_event_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EVENT) |-> (int'(m_axis_tdata[3:0]) < LANES))
    else $error("event from a lane beyond the tree");

endmodule
